FILE: rtl/bkv_pkg.sv
// Shared types and constants for the bounded key/value table.
`default_nettype none
package bkv_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ACTION_W    = 3;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int RANK_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 1;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register index, taken from paddr above the byte offset
  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_UPDATE = 3'd1,
    ACT_UPSERT = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_LOOKUP = 3'd4,
    ACT_RANK   = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COUNT,
    ST_COLLECT,
    ST_FINISH
  } st_e;

  typedef struct packed {
    logic rank_mode;
    logic load_tok;
    logic count_en;
    logic col_en;
    logic wr_ins;
    logic wr_upd;
    logic wr_erase;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/bkv_cell.sv
// One table slot: stored pair, rank token stage and result collection stage.
`default_nettype none
module bkv_cell import bkv_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int INDEX      = 0,
  localparam int CNTW      = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  wire [CNTW-1:0]        count_i,
  input  wire [KEY_BITS-1:0]    req_key_i,
  input  wire [VALUE_BITS-1:0]  req_value_i,
  input  wire [RANK_W-1:0]      req_rank_i,
  input  wire [KEY_BITS-1:0]    nxt_key_i,
  input  wire [VALUE_BITS-1:0]  nxt_value_i,
  input  wire                   seen_i,
  input  wire [KEY_BITS-1:0]    tok_key_i,
  input  wire                   tok_vld_i,
  input  wire                   col_vld_i,
  input  wire [KEY_BITS-1:0]    col_key_i,
  input  wire [VALUE_BITS-1:0]  col_value_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  seen_o,
  output logic [KEY_BITS-1:0]   tok_key_o,
  output logic                  tok_vld_o,
  output logic                  col_vld_o,
  output logic [KEY_BITS-1:0]   col_key_o,
  output logic [VALUE_BITS-1:0] col_value_o
);

  localparam int CMPW = (CNTW > RANK_W) ? CNTW : RANK_W;

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [KEY_BITS-1:0]   tok_key_q, tok_key_d;
  logic                  tok_vld_q, tok_vld_d;
  logic [CNTW-1:0]       smaller_q, smaller_d;
  logic                  col_vld_q, col_vld_d;
  logic [KEY_BITS-1:0]   col_key_q, col_key_d;
  logic [VALUE_BITS-1:0] col_val_q, col_val_d;

  logic occupied, match, rank_hit, hit;

  assign occupied = CNTW'(INDEX) < count_i;
  assign match    = occupied && (key_q == req_key_i);
  assign seen_o   = seen_i | match;
  assign rank_hit = occupied && (CMPW'(smaller_q) == CMPW'(req_rank_i));
  assign hit      = ctrl_i.rank_mode ? rank_hit : match;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctrl_i.wr_erase && seen_o) begin
      key_d = nxt_key_i;
      val_d = nxt_value_i;
    end else if (ctrl_i.wr_ins && (CNTW'(INDEX) == count_i)) begin
      key_d = req_key_i;
      val_d = req_value_i;
    end else if (ctrl_i.wr_upd && match) begin
      val_d = req_value_i;
    end
  end

  always_comb begin
    tok_key_d = tok_key_q;
    tok_vld_d = tok_vld_q;
    smaller_d = smaller_q;
    if (ctrl_i.load_tok) begin
      tok_key_d = key_q;
      tok_vld_d = occupied;
      smaller_d = '0;
    end else if (ctrl_i.count_en) begin
      tok_key_d = tok_key_i;
      tok_vld_d = tok_vld_i;
      if (tok_vld_q && (tok_key_q < key_q)) begin
        smaller_d = smaller_q + CNTW'(1);
      end
    end
  end

  always_comb begin
    col_vld_d = col_vld_q;
    col_key_d = col_key_q;
    col_val_d = col_val_q;
    if (ctrl_i.col_en) begin
      col_vld_d = hit | col_vld_i;
      col_key_d = hit ? key_q : col_key_i;
      col_val_d = hit ? val_q : col_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    val_q     <= val_d;
    tok_key_q <= tok_key_d;
    col_key_q <= col_key_d;
    col_val_q <= col_val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      smaller_q <= '0;
      col_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_d;
      smaller_q <= smaller_d;
      col_vld_q <= col_vld_d;
    end
  end

  assign key_o       = key_q;
  assign value_o     = val_q;
  assign tok_key_o   = tok_key_q;
  assign tok_vld_o   = tok_vld_q;
  assign col_vld_o   = col_vld_q;
  assign col_key_o   = col_key_q;
  assign col_value_o = col_val_q;

endmodule
`default_nettype wire

FILE: rtl/bkv_ctrl.sv
// Sequencer: decodes the action and steps the cell row through its phases.
`default_nettype none
module bkv_ctrl import bkv_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  act_e       action_i,
  input  wire        match_any_i,
  input  wire        room_i,
  input  wire        out_free_i,
  output cell_ctrl_t ctrl_o,
  output logic       res_load_o,
  output logic       res_col_o
);

  localparam int STW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  st_e            state_q, state_d;
  logic [STW-1:0] step_q, step_d;
  logic           last;

  assign last = step_q == STW'(DEPTH - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (action_i)
          ACT_LOOKUP: state_d = ST_COLLECT;
          ACT_RANK:   state_d = ST_COUNT;
          default: begin
            if (out_free_i) state_d = ST_IDLE;
          end
        endcase
      end
      ST_COUNT: begin
        if (last) state_d = ST_COLLECT;
      end
      ST_COLLECT: begin
        if (last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if ((state_q == ST_COUNT) || (state_q == ST_COLLECT)) begin
      step_d = last ? '0 : step_q + STW'(1);
    end
  end

  always_comb begin
    in_ready_o       = 1'b0;
    res_load_o       = 1'b0;
    res_col_o        = 1'b0;
    ctrl_o           = '0;
    ctrl_o.rank_mode = action_i == ACT_RANK;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: begin
        case (action_i)
          ACT_LOOKUP: ;
          ACT_RANK:   ctrl_o.load_tok = 1'b1;
          default: begin
            if (out_free_i) begin
              res_load_o = 1'b1;
              case (action_i)
                ACT_INSERT: ctrl_o.wr_ins = !match_any_i && room_i;
                ACT_UPDATE: ctrl_o.wr_upd = match_any_i;
                ACT_UPSERT: begin
                  ctrl_o.wr_upd = match_any_i;
                  ctrl_o.wr_ins = !match_any_i && room_i;
                end
                ACT_ERASE:  ctrl_o.wr_erase = match_any_i;
                default: ;
              endcase
            end
          end
        endcase
      end
      ST_COUNT:   ctrl_o.count_en = 1'b1;
      ST_COLLECT: ctrl_o.col_en = 1'b1;
      ST_FINISH: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          res_col_o  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bounded_key_value_table_top.sv
// Top level of the bounded key/value table: ports, request and result registers, cell row.
//
//   channel   direction  beat contents
//   s_axis    in         tuser: action; tdata: key, value, rank
//   m_axis    out        tuser: ok; tdata: out_key, out_value, count
//   apb       in/out     register 0: capacity_limit
//
// Insert, update, insert-or-update, erase and no-op: one item at a time, done in the execute step.
// Lookup: execute, then the result collection shifting along the cell row, then finish.
// Select by rank: keys rotate once around the row, then collection.
// Reset empties the table and sets capacity_limit to 16; no clearing pass.
// A result waiting in the output register holds the next item at its final step only.
`default_nettype none
module bounded_key_value_table_top import bkv_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // key[31:0], value[63:32], rank[67:64], zero fill
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // action[2:0]
  input  wire [ACTION_W-1:0]     s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // out_key[31:0], out_value[63:32], count[68:64], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // ok[0]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [APB_ADDR_W-1:0]   paddr,
  input  wire [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [CNTW-1:0]   count_q, count_d;
  act_e              act_q, act_d;
  logic [KW-1:0]     req_key_q, req_key_d;
  logic [VW-1:0]     req_val_q, req_val_d;
  logic [RANK_W-1:0] req_rank_q, req_rank_d;

  logic               m_valid_q, m_valid_d;
  logic               res_ok_q, res_ok_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic [VALUE_W-1:0] res_val_q, res_val_d;
  logic [COUNT_W-1:0] res_cnt_q, res_cnt_d;

  cell_ctrl_t ctrl;
  logic       in_fire, out_free, room, res_load, res_col, cfg_wr;

  logic [KW-1:0] key_w     [DEPTH];
  logic [VW-1:0] val_w     [DEPTH];
  logic          seen_w    [DEPTH];
  logic [KW-1:0] tok_key_w [DEPTH];
  logic          tok_vld_w [DEPTH];
  logic          col_vld_w [DEPTH];
  logic [KW-1:0] col_key_w [DEPTH];
  logic [VW-1:0] col_val_w [DEPTH];

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign room     = (32'(count_q) < 32'(cap_q)) && (32'(count_q) < DEPTH);

  bkv_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (act_q),
    .match_any_i (seen_w[DEPTH-1]),
    .room_i      (room),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .res_load_o  (res_load),
    .res_col_o   (res_col)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KW-1:0] nxt_key, tok_key, col_key;
    logic [VW-1:0] nxt_val, col_val;
    logic          seen_in, tok_vld, col_vld;

    if (i + 1 < DEPTH) begin : g_mid
      assign nxt_key = key_w[i+1];
      assign nxt_val = val_w[i+1];
      assign col_vld = col_vld_w[i+1];
      assign col_key = col_key_w[i+1];
      assign col_val = col_val_w[i+1];
    end else begin : g_tail
      assign nxt_key = key_w[i];
      assign nxt_val = val_w[i];
      assign col_vld = 1'b0;
      assign col_key = '0;
      assign col_val = '0;
    end

    if (i == 0) begin : g_head
      assign seen_in = 1'b0;
    end else begin : g_body
      assign seen_in = seen_w[i-1];
    end

    assign tok_key = tok_key_w[(i + 1) % DEPTH];
    assign tok_vld = tok_vld_w[(i + 1) % DEPTH];

    bkv_cell #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KW),
      .VALUE_BITS (VW),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .req_key_i   (req_key_q),
      .req_value_i (req_val_q),
      .req_rank_i  (req_rank_q),
      .nxt_key_i   (nxt_key),
      .nxt_value_i (nxt_val),
      .seen_i      (seen_in),
      .tok_key_i   (tok_key),
      .tok_vld_i   (tok_vld),
      .col_vld_i   (col_vld),
      .col_key_i   (col_key),
      .col_value_i (col_val),
      .key_o       (key_w[i]),
      .value_o     (val_w[i]),
      .seen_o      (seen_w[i]),
      .tok_key_o   (tok_key_w[i]),
      .tok_vld_o   (tok_vld_w[i]),
      .col_vld_o   (col_vld_w[i]),
      .col_key_o   (col_key_w[i]),
      .col_value_o (col_val_w[i])
    );
  end

  always_comb begin
    act_d      = act_q;
    req_key_d  = req_key_q;
    req_val_d  = req_val_q;
    req_rank_d = req_rank_q;
    if (in_fire) begin
      act_d      = act_e'(s_axis_tuser);
      req_key_d  = s_axis_tdata[KW-1:0];
      req_val_d  = s_axis_tdata[KEY_W +: VW];
      req_rank_d = s_axis_tdata[KEY_W + VALUE_W +: RANK_W];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.wr_ins) begin
      count_d = count_q + CNTW'(1);
    end else if (ctrl.wr_erase) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_comb begin
    res_ok_d  = res_ok_q;
    res_key_d = res_key_q;
    res_val_d = res_val_q;
    res_cnt_d = res_cnt_q;
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    if (res_load) begin
      m_valid_d = 1'b1;
      res_cnt_d = COUNT_W'(count_d);
      if (res_col) begin
        res_ok_d  = col_vld_w[0];
        res_key_d = (col_vld_w[0] && ctrl.rank_mode) ? KEY_W'(col_key_w[0]) : '0;
        res_val_d = col_vld_w[0] ? VALUE_W'(col_val_w[0]) : '0;
      end else begin
        res_ok_d  = ctrl.wr_ins | ctrl.wr_upd | ctrl.wr_erase;
        res_key_d = '0;
        res_val_d = '0;
      end
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);

  always_comb begin
    cap_d = cfg_wr ? pwdata[CAP_W-1:0] : cap_q;
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    req_key_q  <= req_key_d;
    req_val_q  <= req_val_d;
    req_rank_q <= req_rank_d;
    res_ok_q   <= res_ok_d;
    res_key_q  <= res_key_d;
    res_val_q  <= res_val_d;
    res_cnt_q  <= res_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cap_q     <= cap_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_ok_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - KEY_W - VALUE_W - COUNT_W)'(0),
                          res_cnt_q, res_val_q, res_key_q};

  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

endmodule
`default_nettype wire

FILE: rtl/bkv_checker.sv
// Port-level checks for the bounded key/value table, bound to the top level.
`default_nettype none
module bkv_assert import bkv_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid,
  input wire                   s_axis_tready,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire [OUT_TUSER_W-1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while one is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[KEY_W + VALUE_W +: COUNT_W]) <= DEPTH)
    else $error("count beyond table depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[KEY_W + VALUE_W - 1:0] == '0)
    else $error("failed result carries key or value");

endmodule

bind bounded_key_value_table_top bkv_assert #(.DEPTH(DEPTH)) u_bkv_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
